// ===== sv/sett_pkg.sv =====
// ----------------------------------------------------------------------------
// sett_pkg
// Types and constants shared by the edge trigger trace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sett_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_W      = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_OFFSET   = 3'd0,
    CFG_GAIN        = 3'd1,
    CFG_TRIG_LEVEL  = 3'd2,
    CFG_LEVEL_OFS   = 3'd3,
    CFG_SKIP_COUNT  = 3'd4
  } cfg_reg_e;

  // level mapping constants
  localparam logic [24:0] RAW_SCALE  = 25'd396;
  localparam logic [25:0] DC_SUB     = 26'd7864200;
  localparam logic [14:0] LEVEL_BIAS = 15'd240;

  // display point clamp constants
  localparam logic [15:0] PT_BIAS    = 16'd2000;
  localparam logic [15:0] PT_HI_IN   = 16'd2440;
  localparam logic [15:0] PT_LO_IN   = 16'd2040;
  localparam logic [8:0]  PT_HI      = 9'd440;
  localparam logic [8:0]  PT_LO      = 9'd40;
  localparam logic [16:0] TRIG_SPAN  = 17'd3;

  localparam logic        DC_RST     = 1'b1;
  localparam logic [10:0] GAIN_RST   = 11'd256;
  localparam logic [15:0] TRIG_RST   = 16'd240;
  localparam logic [11:0] OFS_RST    = 12'd0;
  localparam logic [9:0]  SKIP_RST   = 10'd200;

  typedef struct packed {
    logic               dc;
    logic [10:0]        gain;
    logic [15:0]        trig;
    logic signed [11:0] offset;
    logic [9:0]         skip;
  } cfg_t;

  typedef struct packed {
    logic        frame_start;
    logic [15:0] level;
  } lvl_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [8:0]       level;
    logic             triggered;
    logic             last;
  } point_t;

endpackage

`default_nettype wire

// ===== sv/sett_level_map.sv =====
// ----------------------------------------------------------------------------
// sett_level_map
// Three-stage pipeline mapping raw adc samples to screen levels.
// ----------------------------------------------------------------------------
`default_nettype none

module sett_level_map (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sett_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  input  wire logic [15:0]       in_sample_i,
  input  wire logic              in_start_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output sett_pkg::lvl_item_t    out_item_o,
  input  wire logic              out_ready_i
);
  import sett_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  logic               st1_q, st2_q;
  logic signed [25:0] p1_d, p1_q;
  logic signed [28:0] x2_d, x2_q;
  lvl_item_t          item3_d, item3_q;

  logic [24:0]        scaled;
  logic signed [36:0] prod;
  logic signed [12:0] q0;
  logic signed [17:0] r0;
  logic signed [13:0] q;
  logic signed [14:0] q_b;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // stage 1: raw * 396 minus dc offset
  assign scaled = 25'(in_sample_i) * RAW_SCALE;
  assign p1_d   = $signed({1'b0, scaled}) - $signed(cfg_i.dc ? DC_SUB : 26'd0);

  // stage 2: times gain, then drop the factor 256 of the divisor
  assign prod = 37'(p1_q) * 37'($signed({1'b0, cfg_i.gain}));
  assign x2_d = prod[36:8];

  // stage 3: floor divide by 65535 via x = q0*65535 + (lo + q0)
  always_comb begin
    q0 = x2_q[28:16];
    r0 = $signed({2'b00, x2_q[15:0]}) + 18'(q0);
    if (r0 >= 18'sd65535) begin
      q = 14'(q0) + 14'sd1;
    end else if (r0 < 18'sd0) begin
      q = 14'(q0) - 14'sd1;
    end else begin
      q = 14'(q0);
    end
    q_b = 15'(q) + $signed(LEVEL_BIAS);
    item3_d.frame_start = st2_q;
    // upper saturation cannot be reached in this value range
    item3_d.level = q_b[14] ? 16'd0 : {2'b00, q_b[13:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      st1_q <= in_start_i;
      p1_q  <= p1_d;
    end
    if (adv2) begin
      st2_q <= st1_q;
      x2_q  <= x2_d;
    end
    if (adv3) begin
      item3_q <= item3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

endmodule

`default_nettype wire

// ===== sv/sett_trace.sv =====
// ----------------------------------------------------------------------------
// sett_trace
// Capture sequencing, falling-edge trigger and display point output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sett_trace #(
  parameter int unsigned LINE_POINTS = 700
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sett_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  input  wire sett_pkg::lvl_item_t in_item_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output sett_pkg::point_t         out_point_o,
  input  wire logic                out_ready_i
);
  import sett_pkg::*;

  localparam logic [IDX_W:0] LP_W = (IDX_W+1)'(LINE_POINTS);

  logic             armed_q, armed_d;
  logic             fin_q, fin_d;
  logic [IDX_W-1:0] post_q, post_d;
  logic [IDX_W-1:0] pre_q, pre_d;
  logic [15:0]      prev_q, prev_d;
  logic [9:0]       seen_q, seen_d;

  logic             out_v_q, out_v_d;
  point_t           point_q, point_d;

  logic             start;
  logic             armed_s, fin_s;
  logic [IDX_W-1:0] post_s, pre_s, idx_sel;
  logic [15:0]      prev_s;
  logic [9:0]       seen_s;
  logic             produce, fire, done, proc, out_free;
  logic [IDX_W:0]   nxt;

  function automatic logic [8:0] clamp_point(input logic [15:0] level,
                                             input logic signed [11:0] ofs);
    logic [15:0] v;
    v = level + 16'($signed(ofs)) + PT_BIAS;
    if (v >= PT_HI_IN) begin
      return PT_HI;
    end else if (v <= PT_LO_IN) begin
      return PT_LO;
    end else begin
      return 9'(v - PT_BIAS);
    end
  endfunction

  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = out_free || !produce;
  assign proc       = in_valid_i && in_ready_o;

  always_comb begin
    start   = in_item_i.frame_start;
    armed_s = start ? 1'b0 : armed_q;
    fin_s   = start ? 1'b0 : fin_q;
    post_s  = start ? '0 : post_q;
    pre_s   = start ? '0 : pre_q;
    prev_s  = start ? 16'd0 : prev_q;
    seen_s  = start ? 10'd0 : seen_q;

    armed_d = armed_s;
    fin_d   = fin_s;
    post_d  = post_s;
    pre_d   = pre_s;
    prev_d  = prev_s;
    seen_d  = seen_s;
    produce = 1'b0;
    fire    = 1'b0;
    done    = 1'b0;
    idx_sel = pre_s;
    nxt     = '0;

    if (!fin_s) begin
      if (seen_s < cfg_i.skip) begin
        seen_d = seen_s + 10'd1;
      end else begin
        produce = 1'b1;
        // window top computed one bit wider so it never wraps
        fire = armed_s
            || (in_item_i.level >= cfg_i.trig
                && {1'b0, in_item_i.level} <= {1'b0, cfg_i.trig} + TRIG_SPAN
                && in_item_i.level < prev_s);
        idx_sel = fire ? post_s : pre_s;
        nxt     = {1'b0, idx_sel} + (IDX_W+1)'(1);
        done    = nxt >= LP_W;
        if (fire) begin
          post_d  = nxt[IDX_W-1:0];
          armed_d = 1'b1;
        end else begin
          pre_d = nxt[IDX_W-1:0];
        end
        if (done) begin
          fin_d = 1'b1;
        end
        prev_d = in_item_i.level;
      end
    end

    point_d.index     = idx_sel;
    point_d.level     = clamp_point(in_item_i.level, cfg_i.offset);
    point_d.triggered = fire;
    point_d.last      = done;

    out_v_d = out_free ? (proc && produce) : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      fin_q   <= 1'b1;
      post_q  <= '0;
      pre_q   <= '0;
      prev_q  <= 16'd0;
      seen_q  <= 10'd0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (proc) begin
        armed_q <= armed_d;
        fin_q   <= fin_d;
        post_q  <= post_d;
        pre_q   <= pre_d;
        prev_q  <= prev_d;
        seen_q  <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      point_q <= point_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_point_o = point_q;

endmodule

`default_nettype wire

// ===== sv/scope_edge_trigger_trace_top.sv =====
// path: an accepted sample is registered in each level map stage, then in the trace output register
// throughput: one sample per cycle while the master side accepts, set by the single-pass trigger and index update
// samples that are skipped or fall outside a capture give no transaction
// reset: asynchronous active low; config returns to defaults, no capture runs
// until a sample marked as frame start arrives
// ----------------------------------------------------------------------------
// scope_edge_trigger_trace_top
// Sample to screen level mapping with falling-edge trigger and trace indexing.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_edge_trigger_trace_top #(
  parameter int unsigned LINE_POINTS = 700
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sett_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sett_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  input  wire logic [15:0]                     s_tdata_i,  // [15:0] sample
  input  wire logic                            s_tuser_i,  // [0] frame_start
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  output logic [23:0]                          m_tdata_o,  // [9:0] point_index,
                                                           // [18:10] point_level
  output logic                                 m_tuser_o,  // [0] triggered
  output logic                                 m_tlast_o
);
  import sett_pkg::*;

  cfg_t      cfg_q;
  logic      map_valid, map_ready;
  lvl_item_t map_item;
  point_t    point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dc     <= DC_RST;
      cfg_q.gain   <= GAIN_RST;
      cfg_q.trig   <= TRIG_RST;
      cfg_q.offset <= OFS_RST;
      cfg_q.skip   <= SKIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DC_OFFSET:  cfg_q.dc     <= cfg_data_i[0];
        CFG_GAIN:       cfg_q.gain   <= cfg_data_i[10:0];
        CFG_TRIG_LEVEL: cfg_q.trig   <= cfg_data_i[15:0];
        CFG_LEVEL_OFS:  cfg_q.offset <= cfg_data_i[11:0];
        CFG_SKIP_COUNT: cfg_q.skip   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  sett_level_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_tvalid_i),
    .in_sample_i (s_tdata_i),
    .in_start_i  (s_tuser_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (map_valid),
    .out_item_o  (map_item),
    .out_ready_i (map_ready)
  );

  sett_trace #(
    .LINE_POINTS (LINE_POINTS)
  ) u_trace (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (map_valid),
    .in_item_i   (map_item),
    .in_ready_o  (map_ready),
    .out_valid_o (m_tvalid_o),
    .out_point_o (point),
    .out_ready_i (m_tready_i)
  );

  assign m_tdata_o = {5'd0, point.level, point.index};
  assign m_tuser_o = point.triggered;
  assign m_tlast_o = point.last;

endmodule

`default_nettype wire

// ===== sv/sett_checker.sv =====
// ----------------------------------------------------------------------------
// sett_checker
// Port-level checks on the trace output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sett_checker #(
  parameter int unsigned LINE_POINTS = 700
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_i,
  input wire logic        m_tready_i,
  input wire logic [23:0] m_tdata_i,
  input wire logic        m_tuser_i,
  input wire logic        m_tlast_i
);

  localparam logic [9:0] LAST_IDX = 10'(LINE_POINTS - 1);

  // a waiting transaction keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i)
      && $stable(m_tuser_i) && $stable(m_tlast_i))
    else $error("output transaction changed while stalled");

  // the closing point of a capture sits in the last column
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i |-> m_tdata_i[9:0] == LAST_IDX)
    else $error("capture ended at wrong column");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[18:10] >= 9'd40 && m_tdata_i[18:10] <= 9'd440
      && m_tdata_i[9:0] <= LAST_IDX && m_tdata_i[23:19] == 5'd0)
    else $error("point level or column out of range");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_i)
    else $error("output valid right after reset");

endmodule

bind scope_edge_trigger_trace_top sett_checker #(
  .LINE_POINTS (LINE_POINTS)
) u_sett_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tuser_i  (m_tuser_o),
  .m_tlast_i  (m_tlast_o)
);

`default_nettype wire

// ===== tb/scope_edge_trigger_trace_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_trigger_trace_top_tb
// Self-checking bench for the sample to trace point block. A local model of
// the level mapping, trigger and indexing predicts each display point, and a
// checker compares every master-side transaction with the oldest prediction.
// ----------------------------------------------------------------------------

module scope_edge_trigger_trace_top_tb;
  import sett_pkg::*;

  localparam int unsigned LINE_PTS     = 700;
  localparam longint      LVL_DEN      = 64'sd16776960;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          PRINT_MAX    = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [15:0] s_tdata_i = '0;
  logic        s_tuser_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;

  scope_edge_trigger_trace_top #(
    .LINE_POINTS(LINE_PTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // model copy of the configuration
  logic              cf_dc    = DC_RST;
  logic [10:0]       cf_gain  = GAIN_RST;
  logic [15:0]       cf_trig  = TRIG_RST;
  logic signed [11:0] cf_ofs  = OFS_RST;
  logic [9:0]        cf_skip  = SKIP_RST;

  // model copy of the capture state
  logic        tr_armed = 1'b0;
  logic [9:0]  tr_post  = '0;
  logic [9:0]  tr_pre   = '0;
  logic [15:0] tr_prev  = '0;
  logic [9:0]  tr_seen  = '0;
  logic        tr_done  = 1'b1;

  point_t exp_points[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit valid_up      = 1'b0;
  int samples_sent  = 0;
  int frames_sent   = 0;
  int points_seen   = 0;
  int post_seen     = 0;
  int ends_seen     = 0;
  int mismatches    = 0;
  logic [15:0] trig_raw = 16'd20000;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  // floor of the scaled sample plus bias, saturated to 16 bits
  function automatic logic [15:0] screen_level(input logic [15:0] raw, input logic dc,
                                               input logic [10:0] gain);
    longint r, d, g, num, q;
    r = raw;
    d = dc;
    g = gain;
    num = (r * 396 - d * 7864200) * g;
    if (num >= 0) q = num / LVL_DEN;
    else q = -((-num + LVL_DEN - 1) / LVL_DEN);
    q = q + 240;
    if (q < 0) q = 0;
    else if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  function automatic logic [8:0] point_row(input logic [15:0] lvl);
    logic [15:0] v;
    v = lvl + {{4{cf_ofs[11]}}, cf_ofs} + PT_BIAS;
    if (v >= PT_HI_IN) return PT_HI;
    if (v <= PT_LO_IN) return PT_LO;
    return 9'(v - PT_BIAS);
  endfunction

  task automatic trace_predict(input logic [15:0] raw, input logic fs);
    logic [15:0] lvl;
    logic        fire;
    logic        done;
    point_t      pt;
    if (fs) begin
      tr_armed = 1'b0;
      tr_post  = '0;
      tr_pre   = '0;
      tr_prev  = '0;
      tr_seen  = '0;
      tr_done  = 1'b0;
    end
    if (tr_done) begin
      // no capture running
    end else if (tr_seen < cf_skip) begin
      tr_seen++;
    end else begin
      lvl  = screen_level(raw, cf_dc, cf_gain);
      // window top computed one bit wider so it cannot wrap
      fire = tr_armed || (lvl >= cf_trig && {1'b0, lvl} <= {1'b0, cf_trig} + TRIG_SPAN
                          && lvl < tr_prev);
      if (fire) begin
        pt.index = tr_post;
        tr_post++;
        tr_armed = 1'b1;
        done = (tr_post >= LINE_PTS);
      end else begin
        pt.index = tr_pre;
        tr_pre++;
        done = (tr_pre >= LINE_PTS);
      end
      if (done) tr_done = 1'b1;
      tr_prev      = lvl;
      pt.level     = point_row(lvl);
      pt.triggered = fire;
      pt.last      = done;
      exp_points.push_back(pt);
    end
  endtask

  task automatic send_sample(input logic [15:0] raw, input logic fs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      if (valid_up) s_tvalid_i <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= raw;
    s_tuser_i  <= fs;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    samples_sent++;
    if (fs) frames_sent++;
    trace_predict(raw, fs);
  endtask

  task automatic wait_drain();
    if (valid_up) s_tvalid_i <= 1'b0;
    valid_up = 1'b0;
    do @(posedge clk_i); while (exp_points.size() != 0);
  endtask

  // skipped samples leave no trace in the queue, so give the pipe time to empty
  task automatic wait_idle();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DC_OFFSET:  cf_dc   = data[0];
      CFG_GAIN:       cf_gain = data[10:0];
      CFG_TRIG_LEVEL: cf_trig = data;
      CFG_LEVEL_OFS:  cf_ofs  = data[11:0];
      CFG_SKIP_COUNT: cf_skip = data[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic dc, input logic [10:0] gain, input logic [15:0] trig,
                            input logic [11:0] ofs, input logic [9:0] skip);
    cfg_write(CFG_DC_OFFSET, {15'd0, dc});
    cfg_write(CFG_GAIN, {5'd0, gain});
    cfg_write(CFG_TRIG_LEVEL, trig);
    cfg_write(CFG_LEVEL_OFS, {4'd0, ofs});
    cfg_write(CFG_SKIP_COUNT, {6'd0, skip});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic        dc;
    logic [10:0] gain;
    logic [15:0] trig;
    logic [11:0] ofs;
    logic [9:0]  skip;
    int          pick;
    dc   = 1'($urandom_range(1));
    pick = $urandom_range(9);
    gain = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd2047 : 11'($urandom_range(64, 1024));
    trig_raw = 16'($urandom);
    pick = $urandom_range(19);
    if (pick == 0) trig = 16'hFFFF;
    else if (pick == 1) trig = 16'h0000;
    else if (pick == 2) trig = 16'($urandom);
    else trig = screen_level(trig_raw, dc, gain) - 16'($urandom_range(2));
    pick = $urandom_range(9);
    ofs  = (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7FF : 12'($urandom);
    skip = ($urandom_range(9) == 0) ? 10'($urandom_range(13, 60)) : 10'($urandom_range(12));
    set_config(dc, gain, trig, ofs, skip);
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk_i) begin : check_points
    point_t want;
    m_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    if (m_tvalid_o && m_tready_i) begin
      if (exp_points.size() == 0) begin
        report_mismatch("display point with none expected, index", m_tdata_o[9:0], -1);
      end else begin
        want = exp_points.pop_front();
        points_seen++;
        if (m_tuser_o) post_seen++;
        if (m_tlast_o) ends_seen++;
        if (m_tdata_o[9:0] != want.index)
          report_mismatch("point_index", m_tdata_o[9:0], want.index);
        if (m_tdata_o[18:10] != want.level)
          report_mismatch("point_level", m_tdata_o[18:10], want.level);
        if (m_tuser_o != want.triggered)
          report_mismatch("triggered", m_tuser_o, want.triggered);
        if (m_tlast_o != want.last)
          report_mismatch("last", m_tlast_o, want.last);
      end
    end
  end

  task automatic test_directed();
    // nothing captured before the first frame start
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    // top-of-range window, full gain, most negative offset: low levels wrap high
    wait_idle();
    set_config(1'b1, 11'd2047, 16'hFFFF, 12'h800, 10'd0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
    // zero gain gives a flat level, largest positive offset
    wait_idle();
    set_config(1'b0, 11'd0, 16'd240, 12'h7FF, 10'd0);
    send_sample(16'h1234, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    // default scaling: 50000 maps to 422, 30000 to 301, 0 to 120
    wait_idle();
    set_config(1'b1, 11'd256, 16'd300, 12'h000, 10'd2);
    send_sample(16'd50000, 1'b1);
    send_sample(16'd50000, 1'b0);
    send_sample(16'd50000, 1'b0);
    send_sample(16'd30000, 1'b0);
    send_sample(16'd60000, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd30000, 1'b1);
    // trigger at the bottom of the level range
    wait_idle();
    set_config(1'b1, 11'd2047, 16'd0, 12'h000, 10'd0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    // longest skip: the whole short capture is swallowed
    wait_idle();
    set_config(1'b0, 11'd1024, 16'd500, 12'h0FF, 10'd1023);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
  endtask

  task automatic test_full_captures();
    // fires on the second sample (516 then 240), post index runs to the end
    wait_idle();
    set_config(1'b1, 11'd256, 16'd240, 12'($urandom), 10'd0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd20000, 1'b0);
    repeat (LINE_PTS + 1) send_sample(16'($urandom), 1'b0);
  endtask

  task automatic test_random_captures(input int budget);
    int          stop_at;
    int          kind;
    int          len;
    int          step_max;
    int          ramp;
    logic [15:0] raw;
    logic        fs;
    stop_at = samples_sent + budget;
    wait_idle();
    random_config();
    while (samples_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        random_config();
      end else if ($urandom_range(7) == 0) begin
        wait_drain();
      end
      kind = $urandom_range(9);
      len  = cf_skip + $urandom_range(1, 60);
      step_max = (cf_gain == 0) ? 4000 : 120000 / cf_gain;
      if (step_max > 4000) step_max = 4000;
      if (step_max < 1) step_max = 1;
      ramp = trig_raw + $urandom_range(0, 20 * step_max);
      if (ramp > 65535) ramp = 65535;
      for (int i = 0; i < len; i++) begin
        // mostly well-formed falling ramps; some noise, stray or missing frame starts
        fs = (i == 0 && kind != 9) || ($urandom_range(49) == 0);
        if (kind < 6 && ramp >= 0) begin
          raw  = 16'(ramp);
          ramp = ramp - $urandom_range(1, step_max);
        end else begin
          raw = 16'($urandom);
        end
        send_sample(raw, fs);
      end
    end
  endtask

  initial begin
    src_idle_pct  = 33;
    sink_idle_pct = 60;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_captures();
    test_random_captures(180);
    src_idle_pct  = 60;
    sink_idle_pct = 33;
    test_random_captures(180);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_captures(180);

    wait_idle();
    $display("sent %0d samples in %0d captures under three idle mixes", samples_sent,
             frames_sent);
    $display("checked %0d display points, %0d post-trigger, %0d capture ends",
             points_seen, post_seen, ends_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("run did not finish in time, %0d points still expected", exp_points.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sett_pkg.sv
sv/sett_level_map.sv
sv/sett_trace.sv
sv/scope_edge_trigger_trace_top.sv
sv/sett_checker.sv
tb/scope_edge_trigger_trace_top_tb.sv
